@@ sv/ipsnr_pkg.sv @@
// Shared types and constants of the PSNR meter.
package ipsnr_pkg;

   localparam int SUM_W      = 40;
   localparam int PEAK_W     = 18;
   localparam int LOG_FRAC   = 24;
   localparam int ITER_W     = 5;
   localparam int MANT_W     = 32;
   localparam int K_W        = 26;
   localparam int PSNR_W     = 16;
   localparam int TOTAL_W    = 23;
   localparam int ROUND_SH   = 39;
   localparam int OUT_SH     = 40;

   localparam logic [PEAK_W-1:0] PEAK3 = 18'd195075;
   localparam logic [K_W-1:0]    K_DB  = 26'd50504453;

   typedef struct packed {
      logic acc_en;
      logic ld_b;
      logic ld_a;
      logic shift;
      logic ld_m;
      logic sq;
      logic sv_b;
      logic diff;
      logic scale;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic sse_zero;
      logic x_top;
      logic it_done;
   } dp_sts_type;

endpackage

@@ sv/ipsnr_dp.sv @@
// Datapath of the PSNR meter: accumulators, log2 unit, scaling and result register.
module ipsnr_dp import ipsnr_pkg::*; #(
   parameter int MAX_PIXELS_LOG2 = 22
) (
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  logic [47:0]        pix_data,
   output dp_sts_type         sts,
   output logic [PSNR_W-1:0]  psnr_db,
   output logic               identical,
   output logic [TOTAL_W-1:0] pixel_total
);

   localparam int CNT_W  = MAX_PIXELS_LOG2 + 1;
   localparam int PROD_W = MAX_PIXELS_LOG2 + PEAK_W;
   localparam int X_W    = (PROD_W > SUM_W) ? PROD_W : SUM_W;
   localparam int EXP_W  = $clog2(X_W);
   localparam int LOG_W  = EXP_W + LOG_FRAC;
   localparam int SCL_W  = LOG_W + K_W + 1;

   logic [SUM_W-1:0]    sse_ff, sse_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [EXP_W-1:0]    e_ff, e_in;
   logic [MANT_W-1:0]   m_ff, m_in;
   logic [LOG_FRAC-1:0] frac_ff, frac_in;
   logic [ITER_W-1:0]   it_ff, it_in;
   logic [LOG_W-1:0]    lb_ff, lb_in;
   logic [LOG_W-1:0]    d_ff, d_in;
   logic [SCL_W-1:0]    scl_ff, scl_in;
   logic [PSNR_W-1:0]   psnr_ff, psnr_in;
   logic                ident_ff, ident_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   logic [7:0]          a0, a1, a2, b0, b1, b2, d0, d1, d2;
   logic [17:0]         pix_err;
   logic [SUM_W:0]      sse_add;
   logic [2*MANT_W-1:0] sq_full;
   logic [MANT_W:0]     sq_top;
   logic [LOG_W-1:0]    la;
   logic [PSNR_W-1:0]   sat_val;

   assign a0 = pix_data[7:0];
   assign a1 = pix_data[15:8];
   assign a2 = pix_data[23:16];
   assign b0 = pix_data[31:24];
   assign b1 = pix_data[39:32];
   assign b2 = pix_data[47:40];

   always_comb begin
      d0 = (a0 > b0) ? (a0 - b0) : (b0 - a0);
      d1 = (a1 > b1) ? (a1 - b1) : (b1 - a1);
      d2 = (a2 > b2) ? (a2 - b2) : (b2 - a2);
      pix_err = 18'(d0 * d0) + 18'(d1 * d1) + 18'(d2 * d2);
      sse_add = {1'b0, sse_ff} + (SUM_W+1)'(pix_err);

      sse_in = sse_ff;
      cnt_in = cnt_ff;
      if (cmd.acc_en && !cnt_ff[CNT_W-1]) begin
         sse_in = sse_add[SUM_W] ? {SUM_W{1'b1}} : sse_add[SUM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.out_load) begin
         sse_in = '0;
         cnt_in = '0;
      end
   end

   assign prod_in = PROD_W'(cnt_ff) * PROD_W'(PEAK3);

   always_comb begin
      sq_full = (2*MANT_W)'(m_ff) * (2*MANT_W)'(m_ff);
      sq_top  = sq_full[2*MANT_W-1:MANT_W-1];
      la      = {e_ff, frac_ff};

      x_in    = x_ff;
      e_in    = e_ff;
      m_in    = m_ff;
      frac_in = frac_ff;
      it_in   = it_ff;
      lb_in   = lb_ff;
      d_in    = d_ff;
      if (cmd.ld_b) begin
         x_in = X_W'(sse_ff);
         e_in = EXP_W'(X_W - 1);
      end
      if (cmd.ld_a) begin
         x_in = X_W'(prod_ff);
         e_in = EXP_W'(X_W - 1);
      end
      if (cmd.shift) begin
         x_in = {x_ff[X_W-2:0], 1'b0};
         e_in = e_ff - 1'b1;
      end
      if (cmd.ld_m) begin
         m_in    = x_ff[X_W-1 -: MANT_W];
         frac_in = '0;
         it_in   = '0;
      end
      if (cmd.sq) begin
         m_in    = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
         frac_in = {frac_ff[LOG_FRAC-2:0], sq_top[MANT_W]};
         it_in   = it_ff + 1'b1;
      end
      if (cmd.sv_b) begin
         lb_in = la;
      end
      if (cmd.diff) begin
         d_in = (la > lb_ff) ? (la - lb_ff) : '0;
      end
   end

   always_comb begin
      scl_in = scl_ff;
      if (cmd.scale) begin
         scl_in = SCL_W'(d_ff) * SCL_W'(K_DB) + (SCL_W'(1) << ROUND_SH);
      end
      sat_val = (scl_ff[SCL_W-1:OUT_SH+PSNR_W] != '0) ? {PSNR_W{1'b1}}
                                                      : scl_ff[OUT_SH+PSNR_W-1:OUT_SH];
      psnr_in  = psnr_ff;
      ident_in = ident_ff;
      total_in = total_ff;
      if (cmd.out_load) begin
         psnr_in  = sts.sse_zero ? '0 : sat_val;
         ident_in = sts.sse_zero;
         total_in = TOTAL_W'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sse_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sse_ff <= sse_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      x_ff     <= x_in;
      e_ff     <= e_in;
      m_ff     <= m_in;
      frac_ff  <= frac_in;
      it_ff    <= it_in;
      lb_ff    <= lb_in;
      d_ff     <= d_in;
      scl_ff   <= scl_in;
      psnr_ff  <= psnr_in;
      ident_ff <= ident_in;
      total_ff <= total_in;
   end

   assign sts.sse_zero = (sse_ff == '0);
   assign sts.x_top    = x_ff[X_W-1];
   assign sts.it_done  = (it_ff == ITER_W'(LOG_FRAC));

   assign psnr_db     = psnr_ff;
   assign identical   = ident_ff;
   assign pixel_total = total_ff;

endmodule

@@ sv/ipsnr_ctrl.sv @@
// Controller of the PSNR meter: sequences accumulation, the two logs and the result.
module ipsnr_ctrl import ipsnr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   input  logic       rsp_tready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       req_tready,
   output logic       rsp_tvalid
);

   typedef enum logic [2:0] {
      RUN,
      CHECK,
      NORM,
      SQUARE,
      SCALE,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      phase_a_ff, phase_a_in;
   logic      out_valid_ff, out_valid_in;
   logic      accept;

   assign req_tready = (state_ff == RUN);
   assign rsp_tvalid = out_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      phase_a_in   = phase_a_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      case (state_ff)
         RUN: begin
            cmd.acc_en = accept;
            if (accept && req_tlast) begin
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (sts.sse_zero) begin
               state_in = FINISH;
            end else begin
               cmd.ld_b   = 1'b1;
               phase_a_in = 1'b0;
               state_in   = NORM;
            end
         end
         NORM: begin
            if (sts.x_top) begin
               cmd.ld_m = 1'b1;
               state_in = SQUARE;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         SQUARE: begin
            if (!sts.it_done) begin
               cmd.sq = 1'b1;
            end else if (!phase_a_ff) begin
               cmd.sv_b   = 1'b1;
               cmd.ld_a   = 1'b1;
               phase_a_in = 1'b1;
               state_in   = NORM;
            end else begin
               cmd.diff = 1'b1;
               state_in = SCALE;
            end
         end
         SCALE: begin
            cmd.scale = 1'b1;
            state_in  = FINISH;
         end
         FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               out_valid_in = 1'b1;
               state_in     = RUN;
            end
         end
         default: begin
            state_in = RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RUN;
         phase_a_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_a_ff   <= phase_a_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

@@ sv/image_psnr_meter.sv @@
// PSNR meter top level: pixel-pair stream in, Q8.8 dB result out.
// Throughput: one pixel pair per cycle while accumulating; a nonzero-error frame result
// is then computed by the shared log2 unit (one shift, then one 32x32 squaring, per cycle).
// No pixels are taken until the result is loaded; the result register holds until taken.
// Synchronous active-high reset clears both accumulators and the handshake state.
module image_psnr_meter import ipsnr_pkg::*; #(
   parameter int MAX_PIXELS_LOG2 = 22
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // first_ch0, first_ch1, first_ch2, second_ch0, second_ch1, second_ch2
   input  logic [47:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // psnr_db[15:0], pixel_total[38:16], zero pad[39]
   output logic [39:0] rsp_tdata,
   // identical
   output logic        rsp_tuser
);

   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic [PSNR_W-1:0]  psnr_db;
   logic [TOTAL_W-1:0] pixel_total;

   ipsnr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid)
   );

   ipsnr_dp #(
      .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .pix_data    (req_tdata),
      .sts         (sts),
      .psnr_db     (psnr_db),
      .identical   (rsp_tuser),
      .pixel_total (pixel_total)
   );

   assign rsp_tdata = {1'b0, pixel_total, psnr_db};

   a_last_stalls_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("input still open after last pixel");

   a_mid_frame_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !req_tlast) |=> req_tready)
      else $error("input closed mid frame");

   a_identical_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("identical result with nonzero psnr");

endmodule
